[design/nva_pkg.sv]
// ----------------------------------------------------------------------------
// nva_pkg: shared types and constants for the vertex normal accumulator
// Item classification, queue entry layout, status codes and sequencer states.
// ----------------------------------------------------------------------------
package nva_pkg;

  localparam int IDX_BITS = 10;
  localparam int SUM_W    = 26;
  localparam int NRM_W    = 16;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_DEGEN = 2'd1;
  localparam logic [1:0] STAT_ZERO  = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_TRI   = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic                idx_ok;
    logic                tri_ok;
    logic [IDX_BITS-1:0] vertex_index;
    logic [IDX_BITS-1:0] corner_a;
    logic [IDX_BITS-1:0] corner_b;
    logic [IDX_BITS-1:0] corner_c;
  } item_t;

  typedef struct packed {
    logic done;
    logic zero;
  } norm_stat_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_LOAD,
    S_RD_A,
    S_RD_B,
    S_RD_C,
    S_EDGE,
    S_CROSS,
    S_RD_SUM,
    S_SUM_WAIT,
    S_NSTART,
    S_NWAIT,
    S_ACC_RD,
    S_ACC_WR,
    S_EMIT
  } back_state_t;

  typedef enum logic [2:0] {
    N_IDLE,
    N_CHECK,
    N_SHIFT,
    N_SQ,
    N_SQRT,
    N_DLOAD,
    N_DIV,
    N_DONE
  } norm_state_t;

endpackage

[design/nva_front.sv]
// ----------------------------------------------------------------------------
// nva_front: command intake
// Classifies each transaction (range checks on indices) and queues it for
// the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module nva_front #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             hold,
  input  logic [1:0]                       in_mode,
  input  logic [nva_pkg::IDX_BITS-1:0]     in_vertex_index,
  input  logic signed [COORD_BITS-1:0]     in_pos_x,
  input  logic signed [COORD_BITS-1:0]     in_pos_y,
  input  logic signed [COORD_BITS-1:0]     in_pos_z,
  input  logic [nva_pkg::IDX_BITS-1:0]     in_corner_a,
  input  logic [nva_pkg::IDX_BITS-1:0]     in_corner_b,
  input  logic [nva_pkg::IDX_BITS-1:0]     in_corner_c,
  output logic                             busy,
  output logic                             q_valid,
  output nva_pkg::item_t                   q_item,
  output logic [3*COORD_BITS-1:0]          q_pos,
  input  logic                             q_pop
);
  import nva_pkg::*;

  item_t                   cls;
  item_t                   item_q_r [2];
  logic [3*COORD_BITS-1:0] pos_q_r  [2];
  logic                    wr_ptr_r;
  logic                    wr_ptr_nxt;
  logic                    rd_ptr_r;
  logic                    rd_ptr_nxt;
  logic [1:0]              cnt_r;
  logic [1:0]              cnt_nxt;
  logic                    push;

  always_comb begin
    cls.op           = op_t'(in_mode);
    cls.idx_ok       = 32'(in_vertex_index) < 32'(MAX_VERTICES);
    cls.tri_ok       = (32'(in_corner_a) < 32'(MAX_VERTICES)) &&
                       (32'(in_corner_b) < 32'(MAX_VERTICES)) &&
                       (32'(in_corner_c) < 32'(MAX_VERTICES));
    cls.vertex_index = in_vertex_index;
    cls.corner_a     = in_corner_a;
    cls.corner_b     = in_corner_b;
    cls.corner_c     = in_corner_c;
  end

  assign busy    = (cnt_r == 2'd2) || hold;
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = item_q_r[rd_ptr_r];
  assign q_pos   = pos_q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    case ({push, q_pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      item_q_r[wr_ptr_r] <= cls;
      pos_q_r[wr_ptr_r]  <= {in_pos_z, in_pos_y, in_pos_x};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[design/nva_norm.sv]
// ----------------------------------------------------------------------------
// nva_norm: iterative unit-length normalizer
// Scales a 3-vector to [2^30, 2^31), sums squares, takes a bit-serial square
// root and divides each component by restoring division into Q1.15.
// ----------------------------------------------------------------------------
module nva_norm #(
  parameter int NW = 35
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [NW-1:0]              vec_x,
  input  logic signed [NW-1:0]              vec_y,
  input  logic signed [NW-1:0]              vec_z,
  output nva_pkg::norm_stat_t               stat,
  output logic signed [nva_pkg::NRM_W-1:0]  o_x,
  output logic signed [nva_pkg::NRM_W-1:0]  o_y,
  output logic signed [nva_pkg::NRM_W-1:0]  o_z
);
  import nva_pkg::*;

  localparam int MW = (NW > 31) ? NW : 31;

  norm_state_t              state_r;
  norm_state_t              state_nxt;
  logic [MW-1:0]            a_r     [3];
  logic [MW-1:0]            a_nxt   [3];
  logic                     neg_r   [3];
  logic                     neg_nxt [3];
  logic signed [NRM_W-1:0]  o_r     [3];
  logic signed [NRM_W-1:0]  o_nxt   [3];
  logic [61:0]              prod_r;
  logic [61:0]              prod_nxt;
  logic [63:0]              sq_r;
  logic [63:0]              sq_nxt;
  logic [63:0]              x_r;
  logic [63:0]              x_nxt;
  logic [63:0]              r_r;
  logic [63:0]              r_nxt;
  logic [63:0]              bit_r;
  logic [63:0]              bit_nxt;
  logic [47:0]              rem_r;
  logic [47:0]              rem_nxt;
  logic [16:0]              q_r;
  logic [16:0]              q_nxt;
  logic [1:0]               k_r;
  logic [1:0]               k_nxt;
  logic [4:0]               it_r;
  logic [4:0]               it_nxt;
  logic                     zero_r;
  logic                     zero_nxt;
  logic [MW-1:0]            m;
  logic [NW-1:0]            vin     [3];
  logic [30:0]              ak;
  logic [63:0]              rb;
  logic [48:0]              dsh;
  logic [14:0]              qc;

  assign vin[0] = vec_x;
  assign vin[1] = vec_y;
  assign vin[2] = vec_z;

  always_comb begin
    m = a_r[0];
    if (a_r[1] > m) m = a_r[1];
    if (a_r[2] > m) m = a_r[2];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      N_IDLE:  if (start) state_nxt = N_CHECK;
      N_CHECK: state_nxt = (m == '0) ? N_DONE : N_SHIFT;
      N_SHIFT: if (((m >> 31) == '0) && ((m >> 30) != '0)) state_nxt = N_SQ;
      N_SQ:    if (k_r == 2'd3) state_nxt = N_SQRT;
      N_SQRT:  if (it_r == 5'd31) state_nxt = N_DLOAD;
      N_DLOAD: state_nxt = N_DIV;
      N_DIV: begin
        if (it_r == 5'd0) state_nxt = (k_r == 2'd2) ? N_DONE : N_DLOAD;
      end
      N_DONE:  state_nxt = N_IDLE;
      default: state_nxt = N_IDLE;
    endcase
  end

  always_comb begin
    a_nxt    = a_r;
    neg_nxt  = neg_r;
    o_nxt    = o_r;
    prod_nxt = prod_r;
    sq_nxt   = sq_r;
    x_nxt    = x_r;
    r_nxt    = r_r;
    bit_nxt  = bit_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    k_nxt    = k_r;
    it_nxt   = it_r;
    zero_nxt = zero_r;
    ak       = a_r[k_r][30:0];
    rb       = r_r + bit_r;
    dsh      = {16'd0, r_r[31:0], 1'b0} << it_r;
    qc       = '0;
    case (state_r)
      N_IDLE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) begin
            neg_nxt[i] = vin[i][NW-1];
            a_nxt[i]   = MW'(vin[i][NW-1] ? (~vin[i] + 1'b1) : vin[i]);
          end
          zero_nxt = 1'b0;
          sq_nxt   = '0;
          k_nxt    = 2'd0;
        end
      end
      N_CHECK: begin
        if (m == '0) begin
          zero_nxt = 1'b1;
          for (int i = 0; i < 3; i++) o_nxt[i] = '0;
        end
      end
      N_SHIFT: begin
        if ((m >> 31) != '0) begin
          for (int i = 0; i < 3; i++) a_nxt[i] = a_r[i] >> 1;
        end else if ((m >> 30) == '0) begin
          for (int i = 0; i < 3; i++) a_nxt[i] = a_r[i] << 1;
        end
      end
      N_SQ: begin
        if (k_r != 2'd3) prod_nxt = ak * ak;
        if (k_r != 2'd0) sq_nxt = sq_r + 64'(prod_r);
        k_nxt = k_r + 2'd1;
        if (k_r == 2'd3) begin
          x_nxt   = sq_r + 64'(prod_r);
          r_nxt   = '0;
          bit_nxt = 64'd1 << 62;
          it_nxt  = 5'd0;
          k_nxt   = 2'd0;
        end
      end
      N_SQRT: begin
        if (x_r >= rb) begin
          x_nxt = x_r - rb;
          r_nxt = (r_r >> 1) + bit_r;
        end else begin
          r_nxt = r_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        it_nxt  = it_r + 5'd1;
      end
      N_DLOAD: begin
        rem_nxt = ({17'd0, ak} << 16) + {16'd0, r_r[31:0]};
        q_nxt   = '0;
        it_nxt  = 5'd16;
      end
      N_DIV: begin
        if ({1'b0, rem_r} >= dsh) begin
          rem_nxt        = 48'({1'b0, rem_r} - dsh);
          q_nxt[it_r]    = 1'b1;
        end
        it_nxt = it_r - 5'd1;
        if (it_r == 5'd0) begin
          qc        = (q_nxt > 17'd32767) ? 15'h7FFF : q_nxt[14:0];
          o_nxt[k_r] = neg_r[k_r] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
          k_nxt     = k_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    neg_r  <= neg_nxt;
    o_r    <= o_nxt;
    prod_r <= prod_nxt;
    sq_r   <= sq_nxt;
    x_r    <= x_nxt;
    r_r    <= r_nxt;
    bit_r  <= bit_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    zero_r <= zero_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      k_r     <= 2'd0;
      it_r    <= 5'd0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      it_r    <= it_nxt;
    end
  end

  assign stat.done = (state_r == N_DONE);
  assign stat.zero = zero_r;
  assign o_x       = o_r[0];
  assign o_y       = o_r[1];
  assign o_z       = o_r[2];

endmodule

[design/nva_back.sv]
// ----------------------------------------------------------------------------
// nva_back: command execution
// Holds the position and normal-sum memories, sequences each queued triangle
// through edge, cross product, normalizer, accumulation; also load/clear/read.
// ----------------------------------------------------------------------------
module nva_back #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  nva_pkg::item_t                    q_item,
  input  logic [3*COORD_BITS-1:0]           q_pos,
  output logic                              q_pop,
  output logic                              init_busy,
  output logic                              out_valid,
  output logic signed [nva_pkg::NRM_W-1:0]  out_normal_x,
  output logic signed [nva_pkg::NRM_W-1:0]  out_normal_y,
  output logic signed [nva_pkg::NRM_W-1:0]  out_normal_z,
  output logic [1:0]                        out_status
);
  import nva_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int EW = COORD_BITS + 1;
  localparam int PW = 2 * EW;
  localparam int CW = 2 * COORD_BITS + 3;
  localparam int NW = (CW > SUM_W) ? CW : SUM_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);

  logic [3*COORD_BITS-1:0] pos_mem [MAX_VERTICES];
  logic [SUM_W-1:0]        sx_mem  [MAX_VERTICES];
  logic [SUM_W-1:0]        sy_mem  [MAX_VERTICES];
  logic [SUM_W-1:0]        sz_mem  [MAX_VERTICES];

  logic                    pos_we;
  logic [AW-1:0]           pos_waddr;
  logic [AW-1:0]           pos_raddr;
  logic [3*COORD_BITS-1:0] pos_rd_r;
  logic                    sum_we;
  logic [AW-1:0]           sum_waddr;
  logic [AW-1:0]           sum_raddr;
  logic [SUM_W-1:0]        sum_wd    [3];
  logic [SUM_W-1:0]        sum_rd_r  [3];

  back_state_t             state_r;
  back_state_t             state_nxt;
  item_t                   item_r;
  item_t                   item_nxt;
  logic [3*COORD_BITS-1:0] ld_r;
  logic [3*COORD_BITS-1:0] ld_nxt;
  logic [3*COORD_BITS-1:0] pa_r;
  logic [3*COORD_BITS-1:0] pa_nxt;
  logic [AW-1:0]           cnt_r;
  logic [AW-1:0]           cnt_nxt;
  logic [1:0]              k_r;
  logic [1:0]              k_nxt;
  logic signed [EW-1:0]    e1_r  [3];
  logic signed [EW-1:0]    e1_nxt[3];
  logic signed [EW-1:0]    e2_r  [3];
  logic signed [EW-1:0]    e2_nxt[3];
  logic signed [PW-1:0]    p1_r;
  logic signed [PW-1:0]    p1_nxt;
  logic signed [PW-1:0]    p2_r;
  logic signed [PW-1:0]    p2_nxt;
  logic signed [NW-1:0]    vec_r  [3];
  logic signed [NW-1:0]    vec_nxt[3];
  logic signed [NRM_W-1:0] fn_r   [3];
  logic signed [NRM_W-1:0] fn_nxt [3];
  logic signed [NRM_W-1:0] res_r  [3];
  logic signed [NRM_W-1:0] res_nxt[3];
  logic [1:0]              st_r;
  logic [1:0]              st_nxt;

  logic                    norm_start;
  norm_stat_t              norm_st;
  logic signed [NRM_W-1:0] norm_o [3];

  function automatic logic signed [EW-1:0] coord(input logic [3*COORD_BITS-1:0] p,
                                                 input logic [1:0] i);
    logic signed [COORD_BITS-1:0] v;
    v = $signed(p[i*COORD_BITS +: COORD_BITS]);
    return EW'(v);
  endfunction

  function automatic logic [AW-1:0] corner_addr(input item_t it, input logic [1:0] k);
    logic [AW-1:0] r;
    case (k)
      2'd0:    r = AW'(it.corner_a);
      2'd1:    r = AW'(it.corner_b);
      default: r = AW'(it.corner_c);
    endcase
    return r;
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                               input logic signed [NRM_W-1:0] d);
    logic signed [SUM_W:0] r;
    r = (SUM_W+1)'(s) + (SUM_W+1)'(d);
    if (r[SUM_W] != r[SUM_W-1]) begin
      return r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return r[SUM_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_waddr] <= ld_r;
    pos_rd_r <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sx_mem[sum_waddr] <= sum_wd[0];
      sy_mem[sum_waddr] <= sum_wd[1];
      sz_mem[sum_waddr] <= sum_wd[2];
    end
    sum_rd_r[0] <= sx_mem[sum_raddr];
    sum_rd_r[1] <= sy_mem[sum_raddr];
    sum_rd_r[2] <= sz_mem[sum_raddr];
  end

  nva_norm #(
    .NW (NW)
  ) u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .vec_x (vec_r[0]),
    .vec_y (vec_r[1]),
    .vec_z (vec_r[2]),
    .stat  (norm_st),
    .o_x   (norm_o[0]),
    .o_y   (norm_o[1]),
    .o_z   (norm_o[2])
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT:  if (cnt_r == LAST_ADDR) state_nxt = S_IDLE;
      S_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            OP_CLEAR: state_nxt = S_CLEAR;
            OP_LOAD:  state_nxt = S_LOAD;
            OP_TRI:   state_nxt = q_item.tri_ok ? S_RD_A : S_EMIT;
            default:  state_nxt = q_item.idx_ok ? S_RD_SUM : S_EMIT;
          endcase
        end
      end
      S_CLEAR:    if (cnt_r == LAST_ADDR) state_nxt = S_EMIT;
      S_LOAD:     state_nxt = S_EMIT;
      S_RD_A:     state_nxt = S_RD_B;
      S_RD_B:     state_nxt = S_RD_C;
      S_RD_C:     state_nxt = S_EDGE;
      S_EDGE:     state_nxt = S_CROSS;
      S_CROSS:    if (k_r == 2'd3) state_nxt = S_NSTART;
      S_RD_SUM:   state_nxt = S_SUM_WAIT;
      S_SUM_WAIT: state_nxt = S_NSTART;
      S_NSTART:   state_nxt = S_NWAIT;
      S_NWAIT: begin
        if (norm_st.done) begin
          state_nxt = (item_r.op == OP_TRI && !norm_st.zero) ? S_ACC_RD : S_EMIT;
        end
      end
      S_ACC_RD:   state_nxt = S_ACC_WR;
      S_ACC_WR:   state_nxt = (k_r == 2'd2) ? S_EMIT : S_ACC_RD;
      S_EMIT:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    item_nxt   = item_r;
    ld_nxt     = ld_r;
    pa_nxt     = pa_r;
    cnt_nxt    = cnt_r;
    k_nxt      = k_r;
    e1_nxt     = e1_r;
    e2_nxt     = e2_r;
    p1_nxt     = p1_r;
    p2_nxt     = p2_r;
    vec_nxt    = vec_r;
    fn_nxt     = fn_r;
    res_nxt    = res_r;
    st_nxt     = st_r;
    q_pop      = 1'b0;
    norm_start = 1'b0;
    pos_we     = 1'b0;
    pos_waddr  = AW'(item_r.vertex_index);
    pos_raddr  = corner_addr(item_r, 2'd0);
    sum_we     = 1'b0;
    sum_waddr  = cnt_r;
    sum_raddr  = corner_addr(item_r, k_r);
    for (int i = 0; i < 3; i++) sum_wd[i] = '0;
    case (state_r)
      S_INIT, S_CLEAR: begin
        sum_we  = 1'b1;
        cnt_nxt = (cnt_r == LAST_ADDR) ? '0 : cnt_r + 1'b1;
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          ld_nxt   = q_pos;
          cnt_nxt  = '0;
          k_nxt    = 2'd0;
          for (int i = 0; i < 3; i++) res_nxt[i] = '0;
          st_nxt   = STAT_OK;
          if (q_item.op == OP_TRI && !q_item.tri_ok) st_nxt = STAT_DEGEN;
          if (q_item.op == OP_READ && !q_item.idx_ok) st_nxt = STAT_ZERO;
        end
      end
      S_LOAD: pos_we = item_r.idx_ok;
      S_RD_A: pos_raddr = corner_addr(item_r, 2'd0);
      S_RD_B: begin
        pos_raddr = corner_addr(item_r, 2'd1);
        pa_nxt    = pos_rd_r;
      end
      S_RD_C: begin
        pos_raddr = corner_addr(item_r, 2'd2);
        for (int i = 0; i < 3; i++) e1_nxt[i] = coord(pos_rd_r, 2'(i)) - coord(pa_r, 2'(i));
      end
      S_EDGE: begin
        for (int i = 0; i < 3; i++) e2_nxt[i] = coord(pos_rd_r, 2'(i)) - coord(pa_r, 2'(i));
        k_nxt = 2'd0;
      end
      S_CROSS: begin
        case (k_r)
          2'd0: begin
            p1_nxt = e1_r[1] * e2_r[2];
            p2_nxt = e1_r[2] * e2_r[1];
          end
          2'd1: begin
            p1_nxt = e1_r[2] * e2_r[0];
            p2_nxt = e1_r[0] * e2_r[2];
          end
          default: begin
            p1_nxt = e1_r[0] * e2_r[1];
            p2_nxt = e1_r[1] * e2_r[0];
          end
        endcase
        if (k_r != 2'd0) vec_nxt[k_r - 2'd1] = NW'(p1_r) - NW'(p2_r);
        k_nxt = k_r + 2'd1;
      end
      S_RD_SUM: sum_raddr = AW'(item_r.vertex_index);
      S_SUM_WAIT: begin
        for (int i = 0; i < 3; i++) vec_nxt[i] = NW'($signed(sum_rd_r[i]));
      end
      S_NSTART: begin
        norm_start = 1'b1;
        k_nxt      = 2'd0;
      end
      S_NWAIT: begin
        if (norm_st.done) begin
          if (item_r.op == OP_TRI) begin
            if (norm_st.zero) st_nxt = STAT_DEGEN;
            else fn_nxt = norm_o;
          end else begin
            res_nxt = norm_o;
            st_nxt  = norm_st.zero ? STAT_ZERO : STAT_OK;
          end
        end
      end
      S_ACC_WR: begin
        sum_we    = 1'b1;
        sum_waddr = corner_addr(item_r, k_r);
        for (int i = 0; i < 3; i++) sum_wd[i] = sat_add($signed(sum_rd_r[i]), fn_r[i]);
        k_nxt     = k_r + 2'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    ld_r   <= ld_nxt;
    pa_r   <= pa_nxt;
    e1_r   <= e1_nxt;
    e2_r   <= e2_nxt;
    p1_r   <= p1_nxt;
    p2_r   <= p2_nxt;
    vec_r  <= vec_nxt;
    fn_r   <= fn_nxt;
    res_r  <= res_nxt;
    st_r   <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cnt_r   <= '0;
      k_r     <= 2'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
    end
  end

  assign init_busy    = (state_r == S_INIT);
  assign out_valid    = (state_r == S_EMIT);
  assign out_normal_x = res_r[0];
  assign out_normal_y = res_r[1];
  assign out_normal_z = res_r[2];
  assign out_status   = st_r;

endmodule

[design/vertex_normal_accumulation.sv]
// ----------------------------------------------------------------------------
// vertex_normal_accumulation: smooth per-vertex normals
// Stores vertex positions, accumulates unit face normals per corner and
// returns normalized vertex sums in Q1.15.
//
//   channel  handshake          fields
//   in_      start / busy       mode, vertex_index, pos_x/y/z, corner_a/b/c
//   out_     out_valid strobe   normal_x/y/z, status
//
// A two-entry queue takes commands while the executor works. Reads and
// triangles pass the normalizer (shift search, 32-step square root, 17-step
// divide per axis); a zero sum or a degenerate triangle skips the root and
// divide. A clear writes one sum per cycle, and after reset busy stays high
// while the sums clear. The receiver cannot stall: each out_valid pulse
// lasts one cycle.
// ----------------------------------------------------------------------------
module vertex_normal_accumulation #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_mode,
  input  logic [nva_pkg::IDX_BITS-1:0]      in_vertex_index,
  input  logic signed [COORD_BITS-1:0]      in_pos_x,
  input  logic signed [COORD_BITS-1:0]      in_pos_y,
  input  logic signed [COORD_BITS-1:0]      in_pos_z,
  input  logic [nva_pkg::IDX_BITS-1:0]      in_corner_a,
  input  logic [nva_pkg::IDX_BITS-1:0]      in_corner_b,
  input  logic [nva_pkg::IDX_BITS-1:0]      in_corner_c,
  output logic                              out_valid,
  output logic signed [nva_pkg::NRM_W-1:0]  out_normal_x,
  output logic signed [nva_pkg::NRM_W-1:0]  out_normal_y,
  output logic signed [nva_pkg::NRM_W-1:0]  out_normal_z,
  output logic [1:0]                        out_status
);
  import nva_pkg::*;

  logic                    q_valid;
  item_t                   q_item;
  logic [3*COORD_BITS-1:0] q_pos;
  logic                    q_pop;
  logic                    init_busy;

  nva_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .hold            (init_busy),
    .in_mode         (in_mode),
    .in_vertex_index (in_vertex_index),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_corner_a     (in_corner_a),
    .in_corner_b     (in_corner_b),
    .in_corner_c     (in_corner_c),
    .busy            (busy),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pos           (q_pos),
    .q_pop           (q_pop)
  );

  nva_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pos        (q_pos),
    .q_pop        (q_pop),
    .init_busy    (init_busy),
    .out_valid    (out_valid),
    .out_normal_x (out_normal_x),
    .out_normal_y (out_normal_y),
    .out_normal_z (out_normal_z),
    .out_status   (out_status)
  );

endmodule
